### hdl/trs_pkg.sv
// Package: payload types for the TRS model-matrix core.
`timescale 1ns / 1ps
`default_nettype none

package trs_pkg;

    localparam int QW = 32;

    typedef struct packed {
        logic signed [QW-1:0] pos_x;
        logic signed [QW-1:0] pos_y;
        logic signed [QW-1:0] pos_z;
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
        logic signed [QW-1:0] quat_w;
        logic signed [QW-1:0] scale_x;
        logic signed [QW-1:0] scale_y;
        logic signed [QW-1:0] scale_z;
    } t_trs_in;

    typedef struct packed {
        logic signed [QW-1:0] m00;
        logic signed [QW-1:0] m01;
        logic signed [QW-1:0] m02;
        logic signed [QW-1:0] m03;
        logic signed [QW-1:0] m10;
        logic signed [QW-1:0] m11;
        logic signed [QW-1:0] m12;
        logic signed [QW-1:0] m13;
        logic signed [QW-1:0] m20;
        logic signed [QW-1:0] m21;
        logic signed [QW-1:0] m22;
        logic signed [QW-1:0] m23;
    } t_trs_out;

endpackage

`default_nettype wire

### hdl/trs_transform_matrix_core.sv
// Top level: four-stage Q16.16 pipeline composing the T*R*S model matrix.
//
//  channel   | ports                   | handshake
//  ----------+-------------------------+------------------------------------
//  item in   | i_item (t_trs_in)       | start high and busy low at the edge
//  result    | o_result (t_trs_out)    | o_done high for one cycle, no stall
//
// One item per cycle.
// Stages: quaternion products, rotation sums with clamp, scale products,
// floor and clamp of the scaled elements into the output register.
// busy stays low: the pipeline never stalls since results cannot be held off.
// Reset clears only the valid bits; data registers are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module trs_transform_matrix_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  trs_pkg::t_trs_in    i_item,
    output logic                o_done,
    output trs_pkg::t_trs_out   o_result
);
    import trs_pkg::*;

    localparam int PW   = 2 * QW;       // full product
    localparam int FRAC = 16;
    localparam int FW   = PW - FRAC;    // floored product
    localparam int RW   = FW + 3;       // rotation sum headroom
    localparam int NE   = 9;

    localparam logic signed [RW-1:0] ONE = RW'(65536);

    function automatic logic signed [QW-1:0] sat(input logic signed [RW-1:0] v);
        logic hi_same;
        hi_same = (v[RW-1:QW-1] == {(RW-QW+1){1'b0}}) ||
                  (v[RW-1:QW-1] == {(RW-QW+1){1'b1}});
        if (hi_same) begin
            return v[QW-1:0];
        end else if (v[RW-1]) begin
            return {1'b1, {(QW-1){1'b0}}};
        end else begin
            return {1'b0, {(QW-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [RW-1:0] ext(input logic signed [FW-1:0] v);
        return {{(RW-FW){v[FW-1]}}, v};
    endfunction

    // stage 1: quaternion products, floored
    logic               r_v1;
    logic signed [FW-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [QW-1:0] r1_px, r1_py, r1_pz, r1_sx, r1_sy, r1_sz;
    logic signed [PW-1:0] n_xx, n_yy, n_zz, n_xy, n_xz, n_yz, n_wx, n_wy, n_wz;

    assign n_xx = i_item.quat_x * i_item.quat_x;
    assign n_yy = i_item.quat_y * i_item.quat_y;
    assign n_zz = i_item.quat_z * i_item.quat_z;
    assign n_xy = i_item.quat_x * i_item.quat_y;
    assign n_xz = i_item.quat_x * i_item.quat_z;
    assign n_yz = i_item.quat_y * i_item.quat_z;
    assign n_wx = i_item.quat_w * i_item.quat_x;
    assign n_wy = i_item.quat_w * i_item.quat_y;
    assign n_wz = i_item.quat_w * i_item.quat_z;

    // stage 2: rotation elements, clamped
    logic               r_v2;
    logic signed [QW-1:0] r_rot [NE];
    logic signed [QW-1:0] r2_px, r2_py, r2_pz, r2_sx, r2_sy, r2_sz;
    logic signed [RW-1:0] n_sum [NE];

    always_comb begin
        n_sum[0] = ONE - (ext(r_yy) <<< 1) - (ext(r_zz) <<< 1);
        n_sum[1] = (ext(r_xy) <<< 1) - (ext(r_wz) <<< 1);
        n_sum[2] = (ext(r_xz) <<< 1) + (ext(r_wy) <<< 1);
        n_sum[3] = (ext(r_xy) <<< 1) + (ext(r_wz) <<< 1);
        n_sum[4] = ONE - (ext(r_xx) <<< 1) - (ext(r_zz) <<< 1);
        n_sum[5] = (ext(r_yz) <<< 1) - (ext(r_wx) <<< 1);
        n_sum[6] = (ext(r_xz) <<< 1) - (ext(r_wy) <<< 1);
        n_sum[7] = (ext(r_yz) <<< 1) + (ext(r_wx) <<< 1);
        n_sum[8] = ONE - (ext(r_xx) <<< 1) - (ext(r_yy) <<< 1);
    end

    // stage 3: scale products, column j takes scale j
    logic               r_v3;
    logic signed [PW-1:0] r_sp [NE];
    logic signed [QW-1:0] r3_px, r3_py, r3_pz;
    logic signed [PW-1:0] n_sp [NE];

    always_comb begin
        for (int i = 0; i < NE; i++) begin
            case (i % 3)
                0:       n_sp[i] = r_rot[i] * r2_sx;
                1:       n_sp[i] = r_rot[i] * r2_sy;
                default: n_sp[i] = r_rot[i] * r2_sz;
            endcase
        end
    end

    // stage 4: floor and clamp into the output register
    logic signed [QW-1:0] n_m [NE];

    always_comb begin
        for (int i = 0; i < NE; i++) begin
            n_m[i] = sat(ext(r_sp[i][PW-1:FRAC]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v1   <= start && !busy;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            o_done <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xx  <= n_xx[PW-1:FRAC];
        r_yy  <= n_yy[PW-1:FRAC];
        r_zz  <= n_zz[PW-1:FRAC];
        r_xy  <= n_xy[PW-1:FRAC];
        r_xz  <= n_xz[PW-1:FRAC];
        r_yz  <= n_yz[PW-1:FRAC];
        r_wx  <= n_wx[PW-1:FRAC];
        r_wy  <= n_wy[PW-1:FRAC];
        r_wz  <= n_wz[PW-1:FRAC];
        r1_px <= i_item.pos_x;
        r1_py <= i_item.pos_y;
        r1_pz <= i_item.pos_z;
        r1_sx <= i_item.scale_x;
        r1_sy <= i_item.scale_y;
        r1_sz <= i_item.scale_z;

        for (int i = 0; i < NE; i++) begin
            r_rot[i] <= sat(n_sum[i]);
        end
        r2_px <= r1_px;
        r2_py <= r1_py;
        r2_pz <= r1_pz;
        r2_sx <= r1_sx;
        r2_sy <= r1_sy;
        r2_sz <= r1_sz;

        for (int i = 0; i < NE; i++) begin
            r_sp[i] <= n_sp[i];
        end
        r3_px <= r2_px;
        r3_py <= r2_py;
        r3_pz <= r2_pz;

        o_result.m00 <= n_m[0];
        o_result.m01 <= n_m[1];
        o_result.m02 <= n_m[2];
        o_result.m03 <= r3_px;
        o_result.m10 <= n_m[3];
        o_result.m11 <= n_m[4];
        o_result.m12 <= n_m[5];
        o_result.m13 <= r3_py;
        o_result.m20 <= n_m[6];
        o_result.m21 <= n_m[7];
        o_result.m22 <= n_m[8];
        o_result.m23 <= r3_pz;
    end

    assign busy = 1'b0;

    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##4 o_done)
        else $error("accepted beat did not come out after four cycles");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##4 !o_done)
        else $error("result strobe without an accepted beat");

    a_trans_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##4 (o_result.m03 == $past(i_item.pos_x, 4)))
        else $error("translation x lost its alignment with the strobe");

    a_trans_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##4 (o_result.m23 == $past(i_item.pos_z, 4)))
        else $error("translation z lost its alignment with the strobe");

endmodule

`default_nettype wire
